FILE: hw/rtl/ffha_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and constants for the first-fit heap allocator
// no dependencies
package ffha_pkg;

  localparam int MAX_CHUNKS   = 64;
  localparam int HEADER_BYTES = 16;
  localparam int IDX_W        = $clog2(MAX_CHUNKS);
  localparam int LINK_W       = IDX_W + 1;
  localparam int OFF_W        = 20;
  localparam int LEN_W        = 21;

  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(MAX_CHUNKS);
  localparam logic [LEN_W-1:0]  SIZE_CAP  = LEN_W'(1048576);
  localparam logic [LEN_W-1:0]  HDR_LEN   = LEN_W'(HEADER_BYTES);

  localparam logic       CMD_ALLOC   = 1'b0;
  localparam logic       CMD_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NULL    = 2'd1;
  localparam logic [1:0] ST_BADADDR = 2'd2;

  localparam logic [1:0] REG_HEAP_BASE = 2'd0;
  localparam logic [1:0] REG_HEAP_SIZE = 2'd1;

  typedef struct packed {
    logic [OFF_W-1:0]  offset;
    logic [LEN_W-1:0]  length;
    logic              in_use;
    logic [LINK_W-1:0] next;
  } chunk_t;

  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              a_we;
    logic [IDX_W-1:0]  a_addr;
    chunk_t            a_data;
    logic              b_we;
    logic [IDX_W-1:0]  b_addr;
    logic [LINK_W-1:0] b_data;
  } tbl_cmd_t;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_WALK, S_SPLIT, S_PREV, S_NEXT, S_WRITE, S_DONE
  } state_t;

endpackage

FILE: hw/rtl/first_fit_heap_allocator.sv
`timescale 1ns / 1ps
// first-fit heap allocator with coalescing: sequencer and result register
// depends on ffha_pkg and ffha_table
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------
//  in      | in_valid / in_ready  | cmd, req_size, release_addr
//  out     | out_valid / out_ready| status, grant_addr
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one item at a time: the first entry is read as the item is accepted, then the
// chunk walk visits one chunk per table read (one table read per cycle), then
// link fixing in S_SPLIT or S_PREV / S_NEXT / S_WRITE and the result load in
// S_DONE complete the item
// reset and every config write to heap base or heap size rebuild entry 0 in S_INIT
// a waiting result holds only the final load; the walk itself never stalls
module first_fit_heap_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [19:0] req_size,
  input  logic [31:0] release_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] grant_addr,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import ffha_pkg::*;

  state_t state, state_next;

  logic [31:0]       heap_base;
  logic [LEN_W-1:0]  heap_size;
  logic [MAX_CHUNKS-1:0] spare;

  // item held for the walk
  logic              cmd_r;
  logic [19:0]       req_r;
  logic [31:0]       rel_r;       // release address relative to heap base

  logic [IDX_W-1:0]  walk;        // chunk whose entry is on the read port
  logic [IDX_W-1:0]  cur_idx;     // chunk being released / merged into
  chunk_t            cur;
  logic [IDX_W-1:0]  cur_gone;    // chunk absorbed by the previous one
  logic [IDX_W-1:0]  split_idx;
  chunk_t            split_chunk;
  logic [1:0]        res_status;
  logic [31:0]       res_addr;

  // index of the predecessor, kept from the walk so the merge knows its home
  logic [IDX_W-1:0]  rd_prev_idx_q;

  tbl_cmd_t          tcmd;
  chunk_t            rd_chunk;
  logic [LINK_W-1:0] rd_prev;

  ffha_table u_table (
    .clk      (clk),
    .cmd_i    (tcmd),
    .rd_chunk (rd_chunk),
    .rd_prev  (rd_prev)
  );

  // lowest spare entry
  logic              spare_hit;
  logic [IDX_W-1:0]  spare_idx;
  always_comb begin
    spare_hit = 1'b0;
    spare_idx = '0;
    for (int i = MAX_CHUNKS - 1; i >= 0; i--) begin
      if (spare[i]) begin
        spare_hit = 1'b1;
        spare_idx = IDX_W'(i);
      end
    end
  end

  logic              in_acc, cfg_acc, cfg_hit, out_free;
  assign in_acc   = in_valid && in_ready;
  assign cfg_acc  = cfg_valid && cfg_ready;
  assign cfg_hit  = cfg_acc && (cfg_index == REG_HEAP_BASE || cfg_index == REG_HEAP_SIZE);
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // walk decisions on the entry just read
  logic              fit, addr_hit, found, do_split, at_end;
  logic [LEN_W:0]    need;
  assign fit      = !rd_chunk.in_use && (rd_chunk.length > {1'b0, req_r});
  assign addr_hit = ({11'd0, {1'b0, rd_chunk.offset} + HDR_LEN[OFF_W:0]} == rel_r);
  assign found    = (cmd_r == CMD_ALLOC) ? fit : addr_hit;
  assign need     = {2'b0, req_r} + {1'b0, HDR_LEN} + (LEN_W+1)'(1);
  assign do_split = ({1'b0, rd_chunk.length} >= need) && spare_hit;
  assign at_end   = (rd_chunk.next == LINK_NONE);

  // merge arithmetic
  chunk_t            merged_prev, merged_next;
  always_comb begin
    merged_prev        = rd_chunk;
    merged_prev.length = rd_chunk.length + cur.length + HDR_LEN;
    merged_prev.in_use = 1'b0;
    merged_prev.next   = cur.next;
    merged_next        = cur;
    if (!rd_chunk.in_use) begin
      merged_next.length = cur.length + rd_chunk.length + HDR_LEN;
      merged_next.next   = rd_chunk.next;
    end
  end

  logic              prev_free, next_link_ok;
  assign prev_free    = !rd_chunk.in_use;
  assign next_link_ok = (merged_prev.next != LINK_NONE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT:  state_next = S_IDLE;
      S_IDLE:  if (in_acc) state_next = S_WALK;
      S_WALK: begin
        if (found) begin
          if (cmd_r == CMD_ALLOC) begin
            state_next = do_split ? S_SPLIT : S_DONE;
          end else if (rd_prev != LINK_NONE) begin
            state_next = S_PREV;
          end else if (!at_end) begin
            state_next = S_NEXT;
          end else begin
            state_next = S_WRITE;
          end
        end else if (at_end) begin
          state_next = S_DONE;
        end
      end
      S_SPLIT: state_next = S_DONE;
      S_PREV: begin
        if (prev_free) state_next = next_link_ok ? S_NEXT : S_WRITE;
        else state_next = (cur.next != LINK_NONE) ? S_NEXT : S_WRITE;
      end
      S_NEXT:  state_next = S_DONE;
      S_WRITE: state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_INIT;
    endcase
    if (cfg_hit) state_next = S_INIT;
  end

  // table port control
  always_comb begin
    tcmd = '0;
    case (state)
      S_INIT: begin
        tcmd.a_we          = 1'b1;
        tcmd.a_addr        = '0;
        tcmd.a_data.offset = '0;
        tcmd.a_data.length = (heap_size > SIZE_CAP) ? SIZE_CAP : heap_size;
        tcmd.a_data.in_use = 1'b0;
        tcmd.a_data.next   = LINK_NONE;
        tcmd.b_we          = 1'b1;
        tcmd.b_addr        = '0;
        tcmd.b_data        = LINK_NONE;
      end
      S_IDLE: begin
        tcmd.rd_en   = in_acc;
        tcmd.rd_addr = '0;
      end
      S_WALK: begin
        if (found) begin
          if (cmd_r == CMD_ALLOC) begin
            tcmd.a_we          = 1'b1;
            tcmd.a_addr        = walk;
            tcmd.a_data        = rd_chunk;
            tcmd.a_data.in_use = 1'b1;
            if (do_split) begin
              tcmd.a_data.length = {1'b0, req_r};
              tcmd.a_data.next   = {1'b0, spare_idx};
              tcmd.b_we          = 1'b1;
              tcmd.b_addr        = spare_idx;
              tcmd.b_data        = {1'b0, walk};
            end
          end else if (rd_prev != LINK_NONE) begin
            tcmd.rd_en   = 1'b1;
            tcmd.rd_addr = rd_prev[IDX_W-1:0];
          end else if (!at_end) begin
            tcmd.rd_en   = 1'b1;
            tcmd.rd_addr = rd_chunk.next[IDX_W-1:0];
          end
        end else if (!at_end) begin
          tcmd.rd_en   = 1'b1;
          tcmd.rd_addr = rd_chunk.next[IDX_W-1:0];
        end
      end
      S_SPLIT: begin
        tcmd.a_we   = 1'b1;
        tcmd.a_addr = split_idx;
        tcmd.a_data = split_chunk;
        if (split_chunk.next != LINK_NONE) begin
          tcmd.b_we   = 1'b1;
          tcmd.b_addr = split_chunk.next[IDX_W-1:0];
          tcmd.b_data = {1'b0, split_idx};
        end
      end
      S_PREV: begin
        if (prev_free) begin
          // the released chunk folds into its free predecessor
          if (next_link_ok) begin
            tcmd.b_we    = 1'b1;
            tcmd.b_addr  = cur.next[IDX_W-1:0];
            tcmd.b_data  = {1'b0, rd_prev_idx_q};
            tcmd.rd_en   = 1'b1;
            tcmd.rd_addr = cur.next[IDX_W-1:0];
          end
        end else if (cur.next != LINK_NONE) begin
          tcmd.rd_en   = 1'b1;
          tcmd.rd_addr = cur.next[IDX_W-1:0];
        end
      end
      S_NEXT: begin
        tcmd.a_we   = 1'b1;
        tcmd.a_addr = cur_idx;
        tcmd.a_data = merged_next;
        if (!rd_chunk.in_use && rd_chunk.next != LINK_NONE) begin
          tcmd.b_we   = 1'b1;
          tcmd.b_addr = rd_chunk.next[IDX_W-1:0];
          tcmd.b_data = {1'b0, cur_idx};
        end
      end
      S_WRITE: begin
        tcmd.a_we   = 1'b1;
        tcmd.a_addr = cur_idx;
        tcmd.a_data = cur;
      end
      S_DONE:  tcmd = '0;
      default: tcmd = '0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
      heap_base <= 32'd0;
      heap_size <= LEN_W'(65536);
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cfg_acc && cfg_index == REG_HEAP_BASE) heap_base <= cfg_data;
      if (cfg_acc && cfg_index == REG_HEAP_SIZE) heap_size <= cfg_data[LEN_W-1:0];
    end
  end

  // spare map: rebuilt whenever the heap is rebuilt
  always_ff @(posedge clk) begin
    if (state == S_INIT) begin
      spare <= {{(MAX_CHUNKS-1){1'b1}}, 1'b0};
    end else if (state == S_WALK && found && cmd_r == CMD_ALLOC && do_split) begin
      spare[spare_idx] <= 1'b0;
    end else if (state == S_PREV && prev_free) begin
      spare[cur_gone] <= 1'b1;
    end else if (state == S_NEXT && !rd_chunk.in_use) begin
      spare[cur.next[IDX_W-1:0]] <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= cmd;
      req_r <= req_size;
      rel_r <= release_addr - heap_base;
      walk  <= '0;
    end
    if (state == S_DONE && out_free) begin
      status     <= res_status;
      grant_addr <= res_addr;
    end
    case (state)
      S_WALK: begin
        if (found) begin
          res_status <= ST_OK;
          res_addr   <= (cmd_r == CMD_ALLOC)
                      ? heap_base + {12'd0, rd_chunk.offset} + 32'(HEADER_BYTES) : 32'd0;
          split_idx          <= spare_idx;
          split_chunk.offset <= rd_chunk.offset + OFF_W'(HEADER_BYTES) + req_r;
          split_chunk.length <= rd_chunk.length - {1'b0, req_r} - HDR_LEN;
          split_chunk.in_use <= 1'b0;
          split_chunk.next   <= rd_chunk.next;
          cur_idx        <= walk;
          cur            <= {rd_chunk.offset, rd_chunk.length, 1'b0, rd_chunk.next};
          cur_gone       <= walk;
        end else begin
          res_status <= (cmd_r == CMD_ALLOC) ? ST_NULL : ST_BADADDR;
          res_addr   <= 32'd0;
          walk       <= rd_chunk.next[IDX_W-1:0];
        end
      end
      S_PREV: begin
        if (prev_free) begin
          cur     <= merged_prev;
          cur_idx <= rd_prev_idx_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_WALK) rd_prev_idx_q <= rd_prev[IDX_W-1:0];
  end

endmodule

FILE: hw/rtl/ffha_table.sv
`timescale 1ns / 1ps
// chunk table: one memory for offset, length, use flag and forward link,
// one for backward links; depends on ffha_pkg
module ffha_table (
  input  logic              clk,
  input  ffha_pkg::tbl_cmd_t cmd_i,
  output ffha_pkg::chunk_t  rd_chunk,
  output logic [ffha_pkg::LINK_W-1:0] rd_prev
);
  import ffha_pkg::*;

  chunk_t            mem_a [MAX_CHUNKS];
  logic [LINK_W-1:0] mem_b [MAX_CHUNKS];

  always_ff @(posedge clk) begin
    if (cmd_i.a_we) begin
      mem_a[cmd_i.a_addr] <= cmd_i.a_data;
    end
    if (cmd_i.rd_en) begin
      rd_chunk <= mem_a[cmd_i.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.b_we) begin
      mem_b[cmd_i.b_addr] <= cmd_i.b_data;
    end
    if (cmd_i.rd_en) begin
      rd_prev <= mem_b[cmd_i.rd_addr];
    end
  end

endmodule
